// ===== rtl/core/set_assoc_cache_lru_sim_unit_defines.svh =====
// Assertion macros for the set-associative cache simulator.
// Used by the top level only; needs nothing else.
`ifndef SET_ASSOC_CACHE_LRU_SIM_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_SIM_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SACL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sacl: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SACL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sacl: next-cycle check failed");

`endif

// ===== rtl/core/sacl_pkg.sv =====
// Shared types and constants for the set-associative cache simulator.
// Depends on nothing; the channels, controller, datapath and top level import it.
`default_nettype none

package sacl_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int WAYS_DEF         = 4;

    localparam int MODE_W     = 2;
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 35;
    localparam int STAMP_W    = 64;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SB_W       = 5;
    localparam int SHIFT_W    = 7;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hffff_ffff;
    localparam logic [STAMP_W-1:0] STAMP_RESET = 64'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_MODIFY = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_BLOCK_BITS  = 2'd1,
        CFG_WAYS_IN_USE = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [STAMP_W-1:0]  stamp;
    } line_t;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic read_row;
        logic match;
        logic scan_step;
        logic fill;
        logic second;
        logic write_back;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic hit;
        logic single_way;
        logic scan_last;
        logic is_modify;
        logic no_access;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/sacl_channels.sv =====
// Handshake channels for the cache simulator: access words in, result words out.
// Depends on sacl_pkg for the payload widths.
`default_nettype none

interface sacl_item_if;
    import sacl_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   address;

    modport source (output valid, output mode, output address, input ready);
    modport sink   (input valid, input mode, input address, output ready);
endinterface

interface sacl_result_if;
    import sacl_pkg::*;

    logic                valid;
    logic                ready;
    logic                first_hit;
    logic                evicted;
    logic [TOTAL_W-1:0]  hit_total;
    logic [TOTAL_W-1:0]  miss_total;
    logic [TOTAL_W-1:0]  eviction_total;

    modport source (output valid, output first_hit, output evicted, output hit_total,
                    output miss_total, output eviction_total, input ready);
    modport sink   (input valid, input first_hit, input evicted, input hit_total,
                    input miss_total, input eviction_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sacl_controller.sv =====
// State machine that sequences the lookup, victim search and write-back of one access.
// Depends on sacl_pkg for the command and status structs.
`default_nettype none

module sacl_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  sacl_pkg::status_t status,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              result_ready,
    output logic              result_valid,
    output sacl_pkg::cmd_t    cmd
);
    import sacl_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_READ   = 8'b0000_0100,
        ST_MATCH  = 8'b0000_1000,
        ST_SCAN   = 8'b0001_0000,
        ST_FILL   = 8'b0010_0000,
        ST_SECOND = 8'b0100_0000,
        ST_WRITE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read_row = 1'b1;
                state_next   = ST_MATCH;
            end
            ST_MATCH:
            begin
                cmd.match = 1'b1;
                priority if (status.no_access)
                begin
                    state_next = ST_WRITE;
                end
                else if (status.hit)
                begin
                    state_next = status.is_modify ? ST_SECOND : ST_WRITE;
                end
                else if (status.single_way)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = status.is_modify ? ST_SECOND : ST_WRITE;
            end
            ST_SECOND:
            begin
                cmd.second = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write_back = 1'b1;
                if (!result_valid_reg || result_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sacl_datapath.sv =====
// Tag store, address decode, hit search, LRU victim scan and running totals.
// Depends on sacl_pkg; driven by sacl_controller through the command struct.
`default_nettype none

module sacl_datapath #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int WAYS         = sacl_pkg::WAYS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sacl_pkg::cmd_t                    cmd,
    output sacl_pkg::status_t                 status,
    input  logic                              cfg_wr_en,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [sacl_pkg::MODE_W-1:0]       item_mode,
    input  logic [sacl_pkg::ADDR_W-1:0]       item_address,
    output logic                              first_hit,
    output logic                              evicted,
    output logic [sacl_pkg::TOTAL_W-1:0]      hit_total,
    output logic [sacl_pkg::TOTAL_W-1:0]      miss_total,
    output logic [sacl_pkg::TOTAL_W-1:0]      eviction_total
);
    import sacl_pkg::*;

    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS  = 1 << MAX_SET_BITS;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
    endfunction

    line_t [WAYS-1:0] mem [NUM_SETS];
    line_t [WAYS-1:0] row_reg;

    logic [2:0]             set_bits_reg;
    logic [5:0]             block_bits_reg;
    logic [2:0]             ways_in_use_reg;

    logic [MODE_W-1:0]      mode_reg;
    logic [SET_IDX_W-1:0]   set_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [SET_IDX_W-1:0]   clear_idx_reg;
    logic [WAY_W-1:0]       victim_reg;
    logic [WAY_W-1:0]       scan_idx_reg;
    logic [STAMP_W-1:0]     stamp_reg;
    logic [TOTAL_W-1:0]     hits_reg;
    logic [TOTAL_W-1:0]     misses_reg;
    logic [TOTAL_W-1:0]     evictions_reg;
    logic                   first_hit_reg;
    logic                   evicted_reg;

    logic                   out_first_hit_reg;
    logic                   out_evicted_reg;
    logic [TOTAL_W-1:0]     out_hits_reg;
    logic [TOTAL_W-1:0]     out_misses_reg;
    logic [TOTAL_W-1:0]     out_evictions_reg;

    logic [SB_W-1:0]        sb;
    logic [SHIFT_W-1:0]     tag_shift;
    logic [ADDR_W-1:0]      shifted;
    logic [SET_IDX_W-1:0]   set_mask;
    logic [WAY_W-1:0]       last_way;
    logic [SB_W-1:0]        ways_ext;
    logic                   hit_any;
    logic [WAY_W-1:0]       hit_way;
    logic                   scan_less;
    logic                   no_access;

    // Clamp the configuration and split the address into set and tag.
    always_comb
    begin
        sb = (SB_W'(set_bits_reg) > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
                                                        : SB_W'(set_bits_reg);
        tag_shift = SHIFT_W'(block_bits_reg) + SHIFT_W'(sb);
        shifted   = item_address >> block_bits_reg;
        for (int i = 0; i < SET_IDX_W; i++)
        begin
            set_mask[i] = (SB_W'(i) < sb);
        end
    end

    always_comb
    begin
        ways_ext = SB_W'(ways_in_use_reg);
        priority if (ways_ext == '0)
        begin
            last_way = '0;
        end
        else if (ways_ext > SB_W'(WAYS))
        begin
            last_way = WAY_W'(WAYS - 1);
        end
        else
        begin
            last_way = WAY_W'(ways_ext - SB_W'(1));
        end
    end

    // The lowest-numbered matching way wins.
    always_comb
    begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row_reg[w].valid && (row_reg[w].tag == tag_reg) && (WAY_W'(w) <= last_way))
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    assign scan_less = row_reg[scan_idx_reg].stamp < row_reg[victim_reg].stamp;
    assign no_access = (mode_reg == MODE_NONE);

    always_comb
    begin
        status            = '0;
        status.clear_done = (clear_idx_reg == SET_IDX_W'(NUM_SETS - 1));
        status.hit        = hit_any;
        status.single_way = (last_way == '0);
        status.scan_last  = (scan_idx_reg == last_way);
        status.is_modify  = (mode_reg == MODE_MODIFY);
        status.no_access  = no_access;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= 3'd4;
            block_bits_reg  <= 6'd4;
            ways_in_use_reg <= 3'd4;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SET_BITS:    set_bits_reg    <= cfg_data[2:0];
                CFG_BLOCK_BITS:  block_bits_reg  <= cfg_data;
                CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= item_mode;
            set_reg  <= shifted[SET_IDX_W-1:0] & set_mask;
            tag_reg  <= TAG_W'(item_address >> tag_shift);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[clear_idx_reg] <= '0;
        end
        else if (cmd.write_back)
        begin
            mem[set_reg] <= row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_row)
        begin
            row_reg <= mem[set_reg];
        end
        else if (cmd.match && hit_any && !no_access)
        begin
            row_reg[hit_way].stamp <= stamp_reg;
        end
        else if (cmd.fill)
        begin
            row_reg[victim_reg].valid <= 1'b1;
            row_reg[victim_reg].tag   <= tag_reg;
            row_reg[victim_reg].stamp <= stamp_reg;
        end
        else if (cmd.second)
        begin
            row_reg[victim_reg].stamp <= stamp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_idx_reg <= '0;
            victim_reg    <= '0;
            scan_idx_reg  <= '0;
            stamp_reg     <= STAMP_RESET;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evictions_reg <= '0;
            first_hit_reg <= 1'b0;
            evicted_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clear_idx_reg <= clear_idx_reg + SET_IDX_W'(1);
            end
            else if (cmd.match)
            begin
                evicted_reg <= 1'b0;
                priority if (no_access)
                begin
                    first_hit_reg <= 1'b0;
                end
                else if (hit_any)
                begin
                    first_hit_reg <= 1'b1;
                    victim_reg    <= hit_way;
                    stamp_reg     <= stamp_reg + STAMP_W'(1);
                    hits_reg      <= sat_inc(hits_reg);
                end
                else
                begin
                    first_hit_reg <= 1'b0;
                    victim_reg    <= '0;
                    scan_idx_reg  <= WAY_W'(1);
                    misses_reg    <= sat_inc(misses_reg);
                end
            end
            else if (cmd.scan_step)
            begin
                if (scan_less)
                begin
                    victim_reg <= scan_idx_reg;
                end
                scan_idx_reg <= scan_idx_reg + WAY_W'(1);
            end
            else if (cmd.fill)
            begin
                stamp_reg <= stamp_reg + STAMP_W'(1);
                if (row_reg[victim_reg].valid)
                begin
                    evicted_reg   <= 1'b1;
                    evictions_reg <= sat_inc(evictions_reg);
                end
            end
            else if (cmd.second)
            begin
                stamp_reg <= stamp_reg + STAMP_W'(1);
                hits_reg  <= sat_inc(hits_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_first_hit_reg <= first_hit_reg;
            out_evicted_reg   <= evicted_reg;
            out_hits_reg      <= hits_reg;
            out_misses_reg    <= misses_reg;
            out_evictions_reg <= evictions_reg;
        end
    end

    assign first_hit      = out_first_hit_reg;
    assign evicted        = out_evicted_reg;
    assign hit_total      = out_hits_reg;
    assign miss_total     = out_misses_reg;
    assign eviction_total = out_evictions_reg;

endmodule

`default_nettype wire

// ===== rtl/core/set_assoc_cache_lru_sim_unit.sv =====
// Top level of the set-associative cache simulator with true-LRU replacement.
// A taken access word passes the read, match and write states on a hit; a miss adds a scan
// step for each further way in use and a fill step, and a modify adds a second-access step.
// The next word is taken back in idle; write waits while a finished result is not taken.
// The single-port tag memory and the victim scan of one way per cycle set this pace.
// After reset a clearing pass empties all 2**MAX_SET_BITS sets before any word is taken.
`default_nettype none

`include "set_assoc_cache_lru_sim_unit_defines.svh"

module set_assoc_cache_lru_sim_unit #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int WAYS         = sacl_pkg::WAYS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
    sacl_item_if.sink                       item,
    sacl_result_if.source                   result
);
    import sacl_pkg::*;

    cmd_t    cmd;
    status_t status;

    sacl_controller u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .cmd          (cmd)
    );

    sacl_datapath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .WAYS         (WAYS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_mode      (item.mode),
        .item_address   (item.address),
        .first_hit      (result.first_hit),
        .evicted        (result.evicted),
        .hit_total      (result.hit_total),
        .miss_total     (result.miss_total),
        .eviction_total (result.eviction_total)
    );

    `SACL_ASSERT_IMP(a_hit_never_evicts, clk, rst_n, result.valid && result.first_hit, !result.evicted)
    `SACL_ASSERT_NXT(a_busy_after_accept, clk, rst_n, item.valid && item.ready, !item.ready)
    `SACL_ASSERT_IMP(a_no_word_while_clearing, clk, rst_n, cmd.clear_step, !item.ready)

endmodule

`default_nettype wire
